@@ hdl/chj_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chj_pkg: shared types and constants of the cuckoo hash join
// Table geometry, item structs, status codes, state encodings and the
// hash and tail helper functions.
// ----------------------------------------------------------------------------
package chj_pkg;

    // table geometry (TABLE_HALF, POOL_DEPTH and QDEPTH are powers of two)
    localparam int TABLE_HALF = 1024;
    localparam int POOL_DEPTH = 4096;
    localparam int NUM_TAILS  = 4;
    localparam int MAX_CHAIN  = 64;
    localparam int HASH_SHIFT = 3;

    // derived widths
    localparam int KEY_W     = 32;
    localparam int CNT_W     = 32;
    localparam int PROD_W    = 64;
    localparam int HALF_W    = $clog2(TABLE_HALF);
    localparam int SLOT_W    = HALF_W + 1;
    localparam int NUM_SLOTS = 2 * TABLE_HALF;
    localparam int ENTRY_W   = $clog2(POOL_DEPTH);
    localparam int USED_W    = ENTRY_W + 1;
    localparam int LEN_W     = $clog2(MAX_CHAIN + 1);
    localparam int KICK_W    = HALF_W + 1;
    localparam int TCNT_W    = 3;
    localparam int SLOT_DW   = ENTRY_W + 1;
    localparam int LINK_DW   = ENTRY_W + 1;
    localparam int TAILS_DW  = NUM_TAILS * KEY_W;

    // command queue between front and back
    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = QPTR_W + 1;

    typedef logic [KEY_W-1:0] word_t;
    typedef logic [NUM_TAILS-1:0][KEY_W-1:0] tails_t;

    typedef enum logic [1:0] {
        OP_CLEAR    = 2'd0,
        OP_BUILD    = 2'd1,
        OP_PROBE    = 2'd2,
        OP_RESERVED = 2'd3
    } opcode_t;

    typedef enum logic [2:0] {
        STAT_DONE       = 3'd0,
        STAT_AGG        = 3'd1,
        STAT_MATCH      = 3'd2,
        STAT_NOMATCH    = 3'd3,
        STAT_POOL_FULL  = 3'd4,
        STAT_CHAIN_FULL = 3'd5,
        STAT_OVERFLOW   = 3'd6
    } status_t;

    typedef enum logic [1:0] {
        K_CLEAR,
        K_BUILD,
        K_PROBE
    } cmd_kind_t;

    typedef struct packed {
        logic [1:0] opcode;
        word_t      join_key;
        word_t      tail_in_0;
        word_t      tail_in_1;
        word_t      tail_in_2;
        word_t      tail_in_3;
        word_t      multiplicity;
    } in_item_t;

    typedef struct packed {
        word_t              match_key;
        word_t              tail_out_0;
        word_t              tail_out_1;
        word_t              tail_out_2;
        word_t              tail_out_3;
        logic [PROD_W-1:0]  joined_count;
        status_t            status;
        logic               last;
    } out_item_t;

    // classified command held in the queue
    typedef struct packed {
        cmd_kind_t          kind;
        word_t              key;
        logic [SLOT_W-1:0]  slot_a;
        logic [SLOT_W-1:0]  slot_b;
        tails_t             tails;
        word_t              mult;
    } cmd_t;

    typedef struct packed {
        logic               init;
        logic [USED_W-1:0]  used;
    } back_status_t;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_CLEAR,
        S_SLOT_RD,
        S_SLOT_CHK,
        S_HEAD_CHK,
        S_WALK,
        S_APPEND,
        S_NEW,
        S_SWAP,
        S_KICK,
        S_OVF,
        S_PROB_MUL,
        S_PROB_EMIT,
        S_REPLY
    } back_state_t;

    // first table: key mod TABLE_HALF
    function automatic logic [SLOT_W-1:0] slot_one(input word_t key);
        return {1'b0, key[HALF_W-1:0]};
    endfunction

    // second table: TABLE_HALF + ((key xor key>>3) mod TABLE_HALF)
    function automatic logic [SLOT_W-1:0] slot_two(input word_t key);
        word_t h;
        h = key ^ (key >> HASH_SHIFT);
        return {1'b1, h[HALF_W-1:0]};
    endfunction

    // zero the tails at or beyond the used count
    function automatic tails_t mask_tails(input tails_t t, input logic [TCNT_W-1:0] n);
        tails_t r;
        for (int i = 0; i < NUM_TAILS; i++) begin
            r[i] = (i < int'(n)) ? t[i] : '0;
        end
        return r;
    endfunction

endpackage

@@ hdl/cuckoo_hash_join.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cuckoo_hash_join: hash join over a two-table cuckoo hash
// Front end queues classified commands, back end runs them on the slot and
// entry memories; one configuration register sets the used tail count.
// ----------------------------------------------------------------------------
//  channel   direction  handshake              payload
//  in        input      in_valid / in_ready    in_data   (in_item_t)
//  out       output     out_valid / out_ready  out_data  (out_item_t)
//  cfg       input      cfg_valid / cfg_ready  cfg_data  (tail count, 3 bits)
//
//  Build: the slot and then the chain head are read; a key not in table one
//  is looked up in table two. A found chain is walked for an equal entry,
//  else a new entry is pushed; a new chain goes into table one, with a cuckoo
//  kick per evicted chain (slot read then swap on the slot memory).
//  Probe: the same lookup, then one match per chain entry, or a no-match result.
//  Clear: one slot per cycle, then the result.
//  After reset the same sweep of the slot memory runs before the
//  first command is taken; the two-deep queue still accepts items meanwhile.
//  Either side may stall independently; results wait in the output register.
// ----------------------------------------------------------------------------
module cuckoo_hash_join
    import chj_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  in_item_t          in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output out_item_t         out_data,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [TCNT_W-1:0] cfg_data
);

    logic [TCNT_W-1:0] tail_fields_used_reg;
    logic [TCNT_W-1:0] tail_count;
    logic              cmd_valid, cmd_ready;
    cmd_t              cmd;
    logic [QCNT_W-1:0] q_count;
    back_status_t      back_stat;

    // configuration register
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tail_fields_used_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            tail_fields_used_reg <= cfg_data;
        end
    end

    // limit the tail count to the number of stored tails
    assign tail_count = (tail_fields_used_reg > TCNT_W'(NUM_TAILS)) ?
                        TCNT_W'(NUM_TAILS) : tail_fields_used_reg;

    chj_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .q_count   (q_count)
    );

    chj_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd_valid),
        .cmd_ready  (cmd_ready),
        .cmd        (cmd),
        .tail_count (tail_count),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data),
        .stat       (back_stat)
    );

    // pool allocation never runs past its depth
    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        back_stat.used <= USED_W'(POOL_DEPTH))
        else $error("entry pool count beyond pool depth");

    // nothing is reported while the slot memory is being swept after reset
    a_init_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        back_stat.init |-> !out_valid)
        else $error("result during reset sweep");

    // an accepted command transaction lands in the queue
    a_queue_push: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && (in_data.opcode == OP_CLEAR ||
         in_data.opcode == OP_BUILD || in_data.opcode == OP_PROBE))
        |=> (q_count != '0))
        else $error("accepted command missing from queue");

endmodule

@@ hdl/chj_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chj_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module chj_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ hdl/chj_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chj_front: input acceptance, classification and command queue
// Decodes the opcode, precomputes both hash slots and queues the command
// for the back end. Reserved opcodes are dropped here.
// ----------------------------------------------------------------------------
module chj_front
    import chj_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  in_item_t          in_data,
    output logic              cmd_valid,
    input  logic              cmd_ready,
    output cmd_t              cmd,
    output logic [QCNT_W-1:0] q_count
);

    cmd_t              q_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    cmd_t              cmd_in;
    logic              known_op;
    logic              push, pop;

    // classify the incoming transaction
    always_comb
    begin
        cmd_in.key    = in_data.join_key;
        cmd_in.slot_a = slot_one(in_data.join_key);
        cmd_in.slot_b = slot_two(in_data.join_key);
        cmd_in.tails  = {in_data.tail_in_3, in_data.tail_in_2,
                         in_data.tail_in_1, in_data.tail_in_0};
        cmd_in.mult   = in_data.multiplicity;
        cmd_in.kind   = K_BUILD;
        known_op      = 1'b1;
        unique case (in_data.opcode)
            OP_CLEAR: cmd_in.kind = K_CLEAR;
            OP_BUILD: cmd_in.kind = K_BUILD;
            OP_PROBE: cmd_in.kind = K_PROBE;
            default:  known_op    = 1'b0;
        endcase
    end

    assign in_ready  = (count_reg != QCNT_W'(QDEPTH));
    assign cmd_valid = (count_reg != '0);
    assign push      = in_valid && in_ready && known_op;
    assign pop       = cmd_valid && cmd_ready;
    assign cmd       = q_reg[rd_ptr_reg];
    assign q_count   = count_reg;

    // queue pointers and fill count
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= cmd_in;
        end
    end

endmodule

@@ hdl/chj_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chj_back: table sequencer of the cuckoo hash join
// Owns the slot and entry memories, walks chains, performs cuckoo kicks,
// sweeps the slot table on clear and drives the output register.
// ----------------------------------------------------------------------------
module chj_back
    import chj_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    output logic              cmd_ready,
    input  cmd_t              cmd,
    input  logic [TCNT_W-1:0] tail_count,
    output logic              out_valid,
    input  logic              out_ready,
    output out_item_t         out_data,
    output back_status_t      stat
);

    back_state_t        state_reg, state_next;
    cmd_t               cmd_reg, cmd_next;
    logic               sel_reg, sel_next;
    logic               first_reg, first_next;
    logic [SLOT_W-1:0]  slot_reg, slot_next;
    logic [SLOT_W-1:0]  clr_reg, clr_next;
    logic [ENTRY_W-1:0] head_reg, head_next;
    logic [ENTRY_W-1:0] ent_reg, ent_next;
    logic [LEN_W-1:0]   len_reg, len_next;
    logic [KICK_W-1:0]  kick_reg, kick_next;
    logic [USED_W-1:0]  used_reg, used_next;
    status_t            rep_status_reg, rep_status_next;
    word_t              rep_key_reg, rep_key_next;
    logic               rep_tails_on_reg, rep_tails_on_next;
    logic [CNT_W-1:0]   rep_count_reg, rep_count_next;
    word_t              prb_key_reg, prb_key_next;
    tails_t             prb_tails_reg, prb_tails_next;
    logic [PROD_W-1:0]  prod_reg, prod_next;
    logic [LINK_DW-1:0] link_reg, link_next;
    logic               more_reg, more_next;
    logic               out_valid_reg, out_valid_next;
    out_item_t          out_data_reg;

    // memory ports
    logic               slot_we;
    logic [SLOT_W-1:0]  slot_waddr, slot_raddr;
    logic [SLOT_DW-1:0] slot_wdata, slot_rdata;
    logic               ent_we, cnt_we;
    logic [ENTRY_W-1:0] ent_waddr, cnt_waddr, ent_raddr;
    logic [KEY_W-1:0]   key_rdata;
    logic [CNT_W-1:0]   cnt_wdata, cnt_rdata;
    logic [TAILS_DW-1:0] tails_rdata;
    logic [LINK_DW-1:0] link_wdata, link_rdata;

    logic               out_free, emit, miss;
    out_item_t          emit_item;
    tails_t             out_tails;
    tails_t             rd_tails;
    logic [CNT_W:0]     sum_wide;
    logic [CNT_W-1:0]   sat_count;
    logic [PROD_W-1:0]  product;
    logic               same_entry;
    logic [LEN_W-1:0]   len_inc;
    logic [KICK_W-1:0]  kick_inc;
    logic [ENTRY_W-1:0] new_ent;
    logic               pool_full;

    chj_ram #(.WIDTH(SLOT_DW), .DEPTH(NUM_SLOTS)) u_slot_ram (
        .clk(clk), .we(slot_we), .waddr(slot_waddr), .wdata(slot_wdata),
        .raddr(slot_raddr), .rdata(slot_rdata)
    );

    chj_ram #(.WIDTH(KEY_W), .DEPTH(POOL_DEPTH)) u_key_ram (
        .clk(clk), .we(ent_we), .waddr(ent_waddr), .wdata(cmd_reg.key),
        .raddr(ent_raddr), .rdata(key_rdata)
    );

    chj_ram #(.WIDTH(CNT_W), .DEPTH(POOL_DEPTH)) u_cnt_ram (
        .clk(clk), .we(cnt_we), .waddr(cnt_waddr), .wdata(cnt_wdata),
        .raddr(ent_raddr), .rdata(cnt_rdata)
    );

    chj_ram #(.WIDTH(TAILS_DW), .DEPTH(POOL_DEPTH)) u_tail_ram (
        .clk(clk), .we(ent_we), .waddr(ent_waddr), .wdata(cmd_reg.tails),
        .raddr(ent_raddr), .rdata(tails_rdata)
    );

    chj_ram #(.WIDTH(LINK_DW), .DEPTH(POOL_DEPTH)) u_link_ram (
        .clk(clk), .we(ent_we), .waddr(ent_waddr), .wdata(link_wdata),
        .raddr(ent_raddr), .rdata(link_rdata)
    );

    // entry datapath: match, saturating add, product
    assign rd_tails   = tails_rdata;
    assign same_entry = (key_rdata == cmd_reg.key) &&
                        (mask_tails(rd_tails, tail_count) ==
                         mask_tails(cmd_reg.tails, tail_count));
    assign sum_wide   = {1'b0, cnt_rdata} + {1'b0, cmd_reg.mult};
    assign sat_count  = sum_wide[CNT_W] ? '1 : sum_wide[CNT_W-1:0];
    assign product    = cnt_rdata * cmd_reg.mult;
    assign len_inc    = len_reg + 1'b1;
    assign kick_inc   = kick_reg + 1'b1;
    assign new_ent    = used_reg[ENTRY_W-1:0];
    assign pool_full  = (used_reg == USED_W'(POOL_DEPTH));
    assign out_free   = !out_valid_reg || out_ready;

    // next state and outputs
    always_comb
    begin
        state_next        = state_reg;
        cmd_next          = cmd_reg;
        sel_next          = sel_reg;
        first_next        = first_reg;
        slot_next         = slot_reg;
        clr_next          = clr_reg;
        head_next         = head_reg;
        ent_next          = ent_reg;
        len_next          = len_reg;
        kick_next         = kick_reg;
        used_next         = used_reg;
        rep_status_next   = rep_status_reg;
        rep_key_next      = rep_key_reg;
        rep_tails_on_next = rep_tails_on_reg;
        rep_count_next    = rep_count_reg;
        prb_key_next      = prb_key_reg;
        prb_tails_next    = prb_tails_reg;
        prod_next         = prod_reg;
        link_next         = link_reg;
        more_next         = more_reg;
        cmd_ready         = 1'b0;
        slot_we           = 1'b0;
        slot_waddr        = slot_reg;
        slot_wdata        = '0;
        slot_raddr        = slot_reg;
        ent_we            = 1'b0;
        ent_waddr         = new_ent;
        link_wdata        = '0;
        cnt_we            = 1'b0;
        cnt_waddr         = new_ent;
        cnt_wdata         = cmd_reg.mult;
        ent_raddr         = ent_reg;
        emit              = 1'b0;
        miss              = 1'b0;
        out_tails         = '0;
        emit_item         = '0;

        unique case (state_reg)
            S_INIT, S_CLEAR:
            begin
                slot_we    = 1'b1;
                slot_waddr = clr_reg;
                slot_wdata = '0;
                clr_next   = clr_reg + 1'b1;
                if (clr_reg == '1)
                begin
                    if (state_reg == S_CLEAR)
                    begin
                        used_next         = '0;
                        rep_status_next   = STAT_DONE;
                        rep_key_next      = '0;
                        rep_tails_on_next = 1'b0;
                        rep_count_next    = '0;
                        state_next        = S_REPLY;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end

            S_IDLE:
            begin
                cmd_ready = 1'b1;
                if (cmd_valid)
                begin
                    cmd_next = cmd;
                    sel_next = 1'b0;
                    clr_next = '0;
                    if (cmd.kind == K_CLEAR)
                    begin
                        state_next = S_CLEAR;
                    end
                    else
                    begin
                        state_next = S_SLOT_RD;
                    end
                end
            end

            S_SLOT_RD:
            begin
                slot_raddr = sel_reg ? cmd_reg.slot_b : cmd_reg.slot_a;
                slot_next  = slot_raddr;
                state_next = S_SLOT_CHK;
            end

            S_SLOT_CHK:
            begin
                if (slot_rdata[ENTRY_W])
                begin
                    head_next  = slot_rdata[ENTRY_W-1:0];
                    ent_next   = slot_rdata[ENTRY_W-1:0];
                    ent_raddr  = slot_rdata[ENTRY_W-1:0];
                    state_next = S_HEAD_CHK;
                end
                else if (!sel_reg)
                begin
                    sel_next   = 1'b1;
                    state_next = S_SLOT_RD;
                end
                else
                begin
                    miss = 1'b1;
                end
            end

            S_HEAD_CHK:
            begin
                if (key_rdata == cmd_reg.key)
                begin
                    len_next   = '0;
                    state_next = (cmd_reg.kind == K_BUILD) ? S_WALK : S_PROB_MUL;
                end
                else if (!sel_reg)
                begin
                    sel_next   = 1'b1;
                    state_next = S_SLOT_RD;
                end
                else
                begin
                    miss = 1'b1;
                end
            end

            // build: search the chain for an equal entry
            S_WALK:
            begin
                if (same_entry)
                begin
                    cnt_we            = 1'b1;
                    cnt_waddr         = ent_reg;
                    cnt_wdata         = sat_count;
                    rep_status_next   = STAT_AGG;
                    rep_key_next      = cmd_reg.key;
                    rep_tails_on_next = 1'b1;
                    rep_count_next    = sat_count;
                    state_next        = S_REPLY;
                end
                else
                begin
                    len_next = len_inc;
                    if (link_rdata[ENTRY_W] && (len_inc < LEN_W'(MAX_CHAIN)))
                    begin
                        ent_next  = link_rdata[ENTRY_W-1:0];
                        ent_raddr = link_rdata[ENTRY_W-1:0];
                    end
                    else
                    begin
                        state_next = S_APPEND;
                    end
                end
            end

            // build: push a new entry onto the found chain
            S_APPEND:
            begin
                rep_key_next      = cmd_reg.key;
                rep_tails_on_next = 1'b1;
                rep_count_next    = '0;
                state_next        = S_REPLY;
                if (pool_full)
                begin
                    rep_status_next = STAT_POOL_FULL;
                end
                else if (len_reg >= LEN_W'(MAX_CHAIN))
                begin
                    rep_status_next = STAT_CHAIN_FULL;
                end
                else
                begin
                    ent_we          = 1'b1;
                    link_wdata      = {1'b1, head_reg};
                    cnt_we          = 1'b1;
                    slot_we         = 1'b1;
                    slot_waddr      = slot_reg;
                    slot_wdata      = {1'b1, new_ent};
                    used_next       = used_reg + 1'b1;
                    rep_status_next = STAT_DONE;
                    rep_count_next  = cmd_reg.mult;
                end
            end

            // build: new chain, first placement in table one
            S_NEW:
            begin
                if (pool_full)
                begin
                    rep_status_next   = STAT_POOL_FULL;
                    rep_key_next      = cmd_reg.key;
                    rep_tails_on_next = 1'b1;
                    rep_count_next    = '0;
                    state_next        = S_REPLY;
                end
                else
                begin
                    ent_we     = 1'b1;
                    link_wdata = '0;
                    cnt_we     = 1'b1;
                    used_next  = used_reg + 1'b1;
                    ent_next   = new_ent;
                    slot_raddr = cmd_reg.slot_a;
                    slot_next  = cmd_reg.slot_a;
                    first_next = 1'b0;
                    kick_next  = '0;
                    state_next = S_SWAP;
                end
            end

            // place the current chain and pick up the evicted one
            S_SWAP:
            begin
                slot_we    = 1'b1;
                slot_waddr = slot_reg;
                slot_wdata = {1'b1, ent_reg};
                ent_next   = slot_rdata[ENTRY_W-1:0];
                ent_raddr  = slot_rdata[ENTRY_W-1:0];
                if (!slot_rdata[ENTRY_W])
                begin
                    rep_status_next   = STAT_DONE;
                    rep_key_next      = cmd_reg.key;
                    rep_tails_on_next = 1'b1;
                    rep_count_next    = cmd_reg.mult;
                    state_next        = S_REPLY;
                end
                else
                begin
                    kick_next  = kick_inc;
                    state_next = (kick_inc == KICK_W'(TABLE_HALF)) ? S_OVF : S_KICK;
                end
            end

            S_KICK:
            begin
                slot_raddr = first_reg ? slot_one(key_rdata) : slot_two(key_rdata);
                slot_next  = slot_raddr;
                first_next = !first_reg;
                state_next = S_SWAP;
            end

            S_OVF:
            begin
                rep_status_next   = STAT_OVERFLOW;
                rep_key_next      = key_rdata;
                rep_tails_on_next = 1'b0;
                rep_count_next    = '0;
                state_next        = S_REPLY;
            end

            // probe: capture one chain entry and its product
            S_PROB_MUL:
            begin
                prod_next      = product;
                prb_key_next   = key_rdata;
                prb_tails_next = rd_tails;
                link_next      = link_rdata;
                more_next      = link_rdata[ENTRY_W] && (len_inc < LEN_W'(MAX_CHAIN));
                state_next     = S_PROB_EMIT;
            end

            S_PROB_EMIT:
            begin
                ent_raddr              = link_reg[ENTRY_W-1:0];
                out_tails              = mask_tails(prb_tails_reg, tail_count);
                emit_item.match_key    = prb_key_reg;
                emit_item.tail_out_0   = out_tails[0];
                emit_item.tail_out_1   = out_tails[1];
                emit_item.tail_out_2   = out_tails[2];
                emit_item.tail_out_3   = out_tails[3];
                emit_item.joined_count = prod_reg;
                emit_item.status       = STAT_MATCH;
                emit_item.last         = !more_reg;
                if (out_free)
                begin
                    emit     = 1'b1;
                    len_next = len_inc;
                    if (more_reg)
                    begin
                        ent_next   = link_reg[ENTRY_W-1:0];
                        state_next = S_PROB_MUL;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end

            S_REPLY:
            begin
                out_tails = rep_tails_on_reg ? mask_tails(cmd_reg.tails, tail_count) : '0;
                emit_item.match_key    = rep_key_reg;
                emit_item.tail_out_0   = out_tails[0];
                emit_item.tail_out_1   = out_tails[1];
                emit_item.tail_out_2   = out_tails[2];
                emit_item.tail_out_3   = out_tails[3];
                emit_item.joined_count = {{(PROD_W-CNT_W){1'b0}}, rep_count_reg};
                emit_item.status       = rep_status_reg;
                emit_item.last         = 1'b1;
                if (out_free)
                begin
                    emit       = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // key found in neither table
        if (miss)
        begin
            if (cmd_reg.kind == K_BUILD)
            begin
                state_next = S_NEW;
            end
            else
            begin
                rep_status_next   = STAT_NOMATCH;
                rep_key_next      = cmd_reg.key;
                rep_tails_on_next = 1'b0;
                rep_count_next    = '0;
                state_next        = S_REPLY;
            end
        end
    end

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            sel_reg       <= 1'b0;
            first_reg     <= 1'b0;
            clr_reg       <= '0;
            len_reg       <= '0;
            kick_reg      <= '0;
            used_reg      <= '0;
            more_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sel_reg       <= sel_next;
            first_reg     <= first_next;
            clr_reg       <= clr_next;
            len_reg       <= len_next;
            kick_reg      <= kick_next;
            used_reg      <= used_next;
            more_reg      <= more_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg          <= cmd_next;
        slot_reg         <= slot_next;
        head_reg         <= head_next;
        ent_reg          <= ent_next;
        rep_status_reg   <= rep_status_next;
        rep_key_reg      <= rep_key_next;
        rep_tails_on_reg <= rep_tails_on_next;
        rep_count_reg    <= rep_count_next;
        prb_key_reg      <= prb_key_next;
        prb_tails_reg    <= prb_tails_next;
        prod_reg         <= prod_next;
        link_reg         <= link_next;
        if (emit)
        begin
            out_data_reg <= emit_item;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign stat.init = (state_reg == S_INIT);
    assign stat.used = used_reg;

endmodule
